FILE: sv/pressure_frame_decode_block_average_defines.svh
// assertion macros for the pressure frame decoder
`ifndef PRESSURE_FRAME_DECODE_BLOCK_AVERAGE_DEFINES_SVH
`define PRESSURE_FRAME_DECODE_BLOCK_AVERAGE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PFDBA_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PFDBA_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PFDBA_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define PFDBA_ASSERT_NEXT(lbl, ck, rstn, ante, cons)
`endif
`endif

FILE: sv/pfdba_pkg.sv
// shared types and constants of the pressure frame decoder
package pfdba_pkg;
	localparam int STATUS_W = 8;
	localparam int RAW_W = 16;
	localparam int TS_W = 48;
	localparam int CNT_W = 7;
	localparam int P_CONV_W = 19;
	localparam int T_CONV_W = 16;
	localparam int P_OUT_W = 19;
	localparam int T_OUT_W = 15;
	localparam int PROD_W = 34;

	localparam int FIXED_BIT = 6;
	localparam int BUSY_BIT = 5;
	localparam int MEMERR_BIT = 2;

	localparam int P_OFFSET = 16384;
	localparam int P_SCALE = 100000;
	localparam int P_SHIFT = 15;
	localparam int T_SHIFT = 4;
	localparam int T_OFFSET = 24;
	localparam int T_STEP = 5;
	localparam int T_BASE = 5000;

	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(10);

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_AVG = 2'd0,
		KIND_NO_FIXED = 2'd1,
		KIND_BUSY = 2'd2,
		KIND_MEM_ERR = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic signed [P_CONV_W-1:0] p_mbar;
		logic signed [T_CONV_W-1:0] t_centi;
		logic [TS_W-1:0] ts;
		logic hall;
		logic sw;
	} item_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV_P,
		BK_DIV_T,
		BK_EMIT
	} back_state_t;
endpackage

FILE: sv/pressure_frame_decode_block_average.sv
// top level of the pressure frame decoder with block averaging
//
// input channel: one sensor reading per item (status, raw pressure and
// temperature, timestamp, hall and switch levels), valid/stall handshake.
// output channel: one record per error reading or per finished block.
// configuration: cfg_wr_en/cfg_wr_data write the samples-per-average count
// (reset value 10); write it only while the block is idle.
// a reading with a bad status gives an error record, registered in the
// front stage, the queue and the output register. a good reading that
// does not end a block gives no record and leaves the back end idle. a
// reading that ends a block gives the averaged record once the shared
// divider, as wide as the pressure accumulator (26 bits with the default
// count limit), has made two passes, pressure then temperature.
// readings keep being taken into the front stage and a two-entry queue
// while the back end divides or the receiver stalls; when both are full,
// in_stall rises. a stalled record holds on the outputs.
// reset clears the sums, the count, the middle-sample values and all valid
// flags; the block is ready, with in_stall low, as soon as reset is over.
module pressure_frame_decode_block_average #(
	parameter int MAX_AVG_COUNT = 100
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [pfdba_pkg::CNT_W-1:0] cfg_wr_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [pfdba_pkg::STATUS_W-1:0] status_byte,
	input  logic [pfdba_pkg::RAW_W-1:0] pressure_raw,
	input  logic [pfdba_pkg::RAW_W-1:0] temperature_raw,
	input  logic [pfdba_pkg::TS_W-1:0] read_timestamp,
	input  logic hall_level,
	input  logic switch_level,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] record_kind,
	output logic signed [pfdba_pkg::P_OUT_W-1:0] avg_pressure_mbar,
	output logic signed [pfdba_pkg::T_OUT_W-1:0] avg_temp_centi,
	output logic [pfdba_pkg::TS_W-1:0] mid_timestamp,
	output logic mid_hall,
	output logic mid_switch
);
	import pfdba_pkg::*;

	logic [CNT_W-1:0] samples_q;
	logic push_valid;
	logic push_stall;
	item_t push_item;
	logic pop_valid;
	logic pop_stall;
	item_t pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_q <= CNT_RESET;
		end else if (cfg_wr_en) begin
			samples_q <= cfg_wr_data;
		end
	end

	pfdba_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status_byte(status_byte),
		.pressure_raw(pressure_raw),
		.temperature_raw(temperature_raw),
		.read_timestamp(read_timestamp),
		.hall_level(hall_level),
		.switch_level(switch_level),
		.push_valid(push_valid),
		.push_stall(push_stall),
		.push_item(push_item)
	);

	pfdba_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_stall(push_stall),
		.push_item(push_item),
		.pop_valid(pop_valid),
		.pop_stall(pop_stall),
		.pop_item(pop_item)
	);

	pfdba_back #(
		.MAX_AVG_COUNT(MAX_AVG_COUNT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.samples_cfg(samples_q),
		.pop_valid(pop_valid),
		.pop_stall(pop_stall),
		.pop_item(pop_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.record_kind(record_kind),
		.avg_pressure_mbar(avg_pressure_mbar),
		.avg_temp_centi(avg_temp_centi),
		.mid_timestamp(mid_timestamp),
		.mid_hall(mid_hall),
		.mid_switch(mid_switch)
	);
endmodule

FILE: sv/pfdba_front.sv
// front end: status check and unit conversion of each reading
module pfdba_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [pfdba_pkg::STATUS_W-1:0] status_byte,
	input  logic [pfdba_pkg::RAW_W-1:0] pressure_raw,
	input  logic [pfdba_pkg::RAW_W-1:0] temperature_raw,
	input  logic [pfdba_pkg::TS_W-1:0] read_timestamp,
	input  logic hall_level,
	input  logic switch_level,
	output logic push_valid,
	input  logic push_stall,
	output pfdba_pkg::item_t push_item
);
	import pfdba_pkg::*;

	localparam logic signed [RAW_W+1:0] P_OFFSET_S = (RAW_W+2)'(P_OFFSET);
	localparam logic signed [PROD_W-1:0] P_SCALE_S = PROD_W'(P_SCALE);
	localparam logic signed [PROD_W-1:0] P_ROUND_S = PROD_W'((2 ** P_SHIFT) - 1);
	localparam logic signed [T_CONV_W-1:0] T_OFFSET_S = T_CONV_W'(T_OFFSET);
	localparam logic signed [T_CONV_W-1:0] T_STEP_S = T_CONV_W'(T_STEP);
	localparam logic signed [T_CONV_W-1:0] T_BASE_S = T_CONV_W'(T_BASE);

	logic valid_s1;
	kind_t kind_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [T_CONV_W-1:0] t_s1;
	logic [TS_W-1:0] ts_s1;
	logic hall_s1;
	logic sw_s1;

	logic advance;
	kind_t kind_d;
	logic signed [RAW_W+1:0] p_diff;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [T_CONV_W-1:0] t_code;
	logic signed [T_CONV_W-1:0] t_d;
	logic signed [PROD_W-1:0] p_bias;
	logic signed [PROD_W-1:0] p_shift;

	always_comb begin
		if (!status_byte[FIXED_BIT]) begin
			kind_d = KIND_NO_FIXED;
		end else if (status_byte[BUSY_BIT]) begin
			kind_d = KIND_BUSY;
		end else if (status_byte[MEMERR_BIT]) begin
			kind_d = KIND_MEM_ERR;
		end else begin
			kind_d = KIND_AVG;
		end
	end

	assign p_diff = $signed({2'b00, pressure_raw}) - P_OFFSET_S;
	assign prod_d = PROD_W'(p_diff) * P_SCALE_S;
	assign t_code = $signed({{T_SHIFT{1'b0}}, temperature_raw[RAW_W-1:T_SHIFT]});
	assign t_d = (t_code - T_OFFSET_S) * T_STEP_S - T_BASE_S;

	assign advance = !valid_s1 || !push_stall;
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			kind_s1 <= kind_d;
			prod_s1 <= prod_d;
			t_s1 <= t_d;
			ts_s1 <= read_timestamp;
			hall_s1 <= hall_level;
			sw_s1 <= switch_level;
		end
	end

	// divide by 2^15 rounding toward zero
	assign p_bias = prod_s1 + (prod_s1[PROD_W-1] ? P_ROUND_S : '0);
	assign p_shift = p_bias >>> P_SHIFT;

	assign push_valid = valid_s1;
	assign push_item.kind = kind_s1;
	assign push_item.p_mbar = p_shift[P_CONV_W-1:0];
	assign push_item.t_centi = t_s1;
	assign push_item.ts = ts_s1;
	assign push_item.hall = hall_s1;
	assign push_item.sw = sw_s1;
endmodule

FILE: sv/pfdba_queue.sv
// short queue between front and back end
`include "pressure_frame_decode_block_average_defines.svh"
module pfdba_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_stall,
	input  pfdba_pkg::item_t push_item,
	output logic pop_valid,
	input  logic pop_stall,
	output pfdba_pkg::item_t pop_item
);
	import pfdba_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	item_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign push_stall = (count_q == FULL_CNT);
	assign pop_valid = (count_q != '0);
	assign push = push_valid && !push_stall;
	assign pop = pop_valid && !pop_stall;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`PFDBA_ASSERT_IMP(a_queue_bound, clk, arst_n, 1'b1, count_q <= FULL_CNT)
endmodule

FILE: sv/pfdba_div.sv
// shared restoring divider, one quotient bit per cycle
`include "pressure_frame_decode_block_average_defines.svh"
module pfdba_div #(
	parameter int W = 26
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [W-1:0] dividend,
	input  logic [pfdba_pkg::CNT_W-1:0] divisor,
	output logic done,
	output logic [W-1:0] quotient
);
	import pfdba_pkg::*;

	localparam int STEP_W = $clog2(W + 1);
	localparam logic [STEP_W-1:0] STEPS = STEP_W'(W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(1);

	logic busy_q;
	logic done_q;
	logic [STEP_W-1:0] step_q;
	logic [W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W:0] rem_sh;
	logic [CNT_W:0] rem_diff;
	logic fits;

	assign rem_sh = {rem_q, quo_q[W-1]};
	assign rem_diff = rem_sh - {1'b0, divisor};
	assign fits = (rem_sh >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEPS;
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], fits};
			rem_q <= fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

	`PFDBA_ASSERT_IMP(a_div_done_idle, clk, arst_n, done_q, !busy_q)
endmodule

FILE: sv/pfdba_back.sv
// back end: accumulation, middle-sample capture, averaging and output register
`include "pressure_frame_decode_block_average_defines.svh"
module pfdba_back #(
	parameter int MAX_AVG_COUNT = 100
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [pfdba_pkg::CNT_W-1:0] samples_cfg,
	input  logic pop_valid,
	output logic pop_stall,
	input  pfdba_pkg::item_t pop_item,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] record_kind,
	output logic signed [pfdba_pkg::P_OUT_W-1:0] avg_pressure_mbar,
	output logic signed [pfdba_pkg::T_OUT_W-1:0] avg_temp_centi,
	output logic [pfdba_pkg::TS_W-1:0] mid_timestamp,
	output logic mid_hall,
	output logic mid_switch
);
	import pfdba_pkg::*;

	localparam int CNT_MAX = (1 << CNT_W) - 1;
	localparam int N_CAP_I = (MAX_AVG_COUNT < CNT_MAX) ? MAX_AVG_COUNT : CNT_MAX;
	localparam logic [CNT_W-1:0] N_CAP = CNT_W'(N_CAP_I);
	localparam int EXT_W = $clog2(N_CAP_I + 1);
	localparam int P_ACC_W = P_CONV_W + EXT_W;
	localparam int T_ACC_W = T_CONV_W + EXT_W;

	back_state_t state_q;
	back_state_t state_d;

	logic [CNT_W-1:0] cnt_q;
	logic signed [P_ACC_W-1:0] psum_q;
	logic signed [T_ACC_W-1:0] tsum_q;
	logic [TS_W-1:0] held_ts_q;
	logic held_hall_q;
	logic held_sw_q;
	logic p_neg_q;
	logic signed [T_ACC_W-1:0] num_t_q;
	logic [CNT_W-1:0] div_n_q;
	logic [P_OUT_W-1:0] avg_p_q;
	logic [T_OUT_W-1:0] avg_t_q;

	logic out_valid_q;
	kind_t out_kind_q;
	logic [P_OUT_W-1:0] out_p_q;
	logic [T_OUT_W-1:0] out_t_q;
	logic [TS_W-1:0] out_ts_q;
	logic out_hall_q;
	logic out_sw_q;

	logic [CNT_W-1:0] n_eff;
	logic [CNT_W:0] n_inc;
	logic [CNT_W-1:0] n_mid;
	logic out_free;
	logic pop;
	logic good_pop;
	logic err_pop;
	logic [CNT_W-1:0] cnt_next;
	logic signed [P_ACC_W-1:0] psum_next;
	logic signed [T_ACC_W-1:0] tsum_next;
	logic block_end;
	logic [P_ACC_W-1:0] p_mag;
	logic [T_ACC_W-1:0] t_mag;
	logic div_start;
	logic [P_ACC_W-1:0] div_dividend;
	logic div_done;
	logic [P_ACC_W-1:0] div_quo;
	logic [P_ACC_W-1:0] quo_signed;
	logic load_avg;

	always_comb begin
		if (samples_cfg == '0) begin
			n_eff = CNT_W'(1);
		end else if (samples_cfg > N_CAP) begin
			n_eff = N_CAP;
		end else begin
			n_eff = samples_cfg;
		end
	end

	assign n_inc = {1'b0, n_eff} + 1'b1;
	assign n_mid = n_inc[CNT_W:1];
	assign out_free = !out_valid_q || !out_stall;

	assign cnt_next = cnt_q + 1'b1;
	assign psum_next = psum_q
		+ {{(P_ACC_W-P_CONV_W){pop_item.p_mbar[P_CONV_W-1]}}, pop_item.p_mbar};
	assign tsum_next = tsum_q
		+ {{(T_ACC_W-T_CONV_W){pop_item.t_centi[T_CONV_W-1]}}, pop_item.t_centi};
	assign block_end = (cnt_next >= n_eff);

	assign p_mag = psum_next[P_ACC_W-1] ? (~psum_next + 1'b1) : psum_next;
	assign t_mag = num_t_q[T_ACC_W-1] ? (~num_t_q + 1'b1) : num_t_q;

	always_comb begin
		state_d = state_q;
		pop_stall = 1'b1;
		div_start = 1'b0;
		div_dividend = p_mag;
		load_avg = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop_stall = !((pop_item.kind == KIND_AVG) || out_free);
				if (pop_valid && pop_item.kind == KIND_AVG && block_end) begin
					div_start = 1'b1;
					state_d = BK_DIV_P;
				end
			end
			BK_DIV_P: begin
				div_dividend = {{(P_ACC_W-T_ACC_W){1'b0}}, t_mag};
				if (div_done) begin
					div_start = 1'b1;
					state_d = BK_DIV_T;
				end
			end
			BK_DIV_T: begin
				if (div_done) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (out_free) begin
					load_avg = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	assign pop = pop_valid && !pop_stall;
	assign good_pop = pop && (pop_item.kind == KIND_AVG);
	assign err_pop = pop && (pop_item.kind != KIND_AVG);

	pfdba_div #(
		.W(P_ACC_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_n_q),
		.done(div_done),
		.quotient(div_quo)
	);

	// sign of the quotient follows the sum being divided
	always_comb begin
		if (state_q == BK_DIV_P) begin
			quo_signed = p_neg_q ? (~div_quo + 1'b1) : div_quo;
		end else begin
			quo_signed = num_t_q[T_ACC_W-1] ? (~div_quo + 1'b1) : div_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			psum_q <= '0;
			tsum_q <= '0;
			held_ts_q <= '0;
			held_hall_q <= 1'b0;
			held_sw_q <= 1'b0;
		end else if (good_pop) begin
			if (cnt_next == n_mid) begin
				held_ts_q <= pop_item.ts;
				held_hall_q <= pop_item.hall;
				held_sw_q <= pop_item.sw;
			end
			if (block_end) begin
				cnt_q <= '0;
				psum_q <= '0;
				tsum_q <= '0;
			end else begin
				cnt_q <= cnt_next;
				psum_q <= psum_next;
				tsum_q <= tsum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (good_pop && block_end) begin
			p_neg_q <= psum_next[P_ACC_W-1];
			num_t_q <= tsum_next;
			div_n_q <= n_eff;
		end
		if (state_q == BK_DIV_P && div_done) begin
			avg_p_q <= quo_signed[P_OUT_W-1:0];
		end
		if (state_q == BK_DIV_T && div_done) begin
			avg_t_q <= quo_signed[T_OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (err_pop || load_avg) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (err_pop) begin
			out_kind_q <= pop_item.kind;
			out_p_q <= '0;
			out_t_q <= '0;
			out_ts_q <= '0;
			out_hall_q <= 1'b0;
			out_sw_q <= 1'b0;
		end else if (load_avg) begin
			out_kind_q <= KIND_AVG;
			out_p_q <= avg_p_q;
			out_t_q <= avg_t_q;
			out_ts_q <= held_ts_q;
			out_hall_q <= held_hall_q;
			out_sw_q <= held_sw_q;
		end
	end

	assign out_valid = out_valid_q;
	assign record_kind = out_kind_q;
	assign avg_pressure_mbar = out_p_q;
	assign avg_temp_centi = out_t_q;
	assign mid_timestamp = out_ts_q;
	assign mid_hall = out_hall_q;
	assign mid_switch = out_sw_q;

	`PFDBA_ASSERT_NEXT(a_err_to_out, clk, arst_n, err_pop, out_valid_q)
	`PFDBA_ASSERT_IMP(a_done_in_div, clk, arst_n, div_done,
		(state_q == BK_DIV_P) || (state_q == BK_DIV_T))
	`PFDBA_ASSERT_IMP(a_sums_clear, clk, arst_n, state_q != BK_IDLE,
		(cnt_q == '0) && (psum_q == '0) && (tsum_q == '0))
endmodule
